// File: design/led_pkg.sv
// ----------------------------------------------------------------------------
// led_pkg: shared types and constants of the expected-delay dispatcher
// Request and result payloads, configuration register map and the
// classified request that travels from the front end to the back end.
// ----------------------------------------------------------------------------
package led_pkg;

	localparam int ID_W      = 16;
	localparam int ITEMS_W   = 8;
	localparam int SVC_W     = 8;
	localparam int LANE_W    = 2;
	localparam int WAIT_W    = 16;
	localparam int RATE_W    = 4;
	localparam int NLANES_W  = 3;
	localparam int CFG_IDX_W = 3;
	localparam int CFG_DAT_W = 4;
	localparam int RATE_REGS = 4;
	localparam int WORD_W    = ID_W + ITEMS_W + SVC_W;

	// Configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_LANES = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_RATE0 = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_RATE1 = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_RATE2 = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_RATE3 = 3'd4;

	// Raw request type codes
	localparam logic REQ_ARRIVE = 1'b0;
	localparam logic REQ_SERVE  = 1'b1;

	// Reset values of the configuration registers
	localparam logic [NLANES_W-1:0] LANES_RST = 3'd4;
	localparam logic [RATE_W-1:0]   RATE_RST  = 4'd2;

	typedef enum logic [1:0] {
		KIND_ARRIVE,
		KIND_SERVE,
		KIND_SERVE_NONE
	} req_kind_t;

	typedef struct packed {
		req_kind_t           kind;
		logic [LANE_W-1:0]   lane;
		logic [ID_W-1:0]     job_id;
		logic [ITEMS_W-1:0]  job_items;
		logic [SVC_W-1:0]    job_service;
	} req_t;

	typedef struct packed {
		logic [LANE_W-1:0]   chosen_lane;
		logic [WAIT_W-1:0]   est_wait;
		logic                lane_full;
		logic                lane_empty;
		logic [ID_W-1:0]     out_job_id;
		logic [ITEMS_W-1:0]  out_items;
		logic [SVC_W-1:0]    out_service;
	} res_t;

	typedef struct packed {
		logic [NLANES_W-1:0]                lanes_in_use;
		logic [RATE_REGS-1:0][RATE_W-1:0]   rate;
	} cfg_t;

endpackage

// File: design/led_req_if.sv
// ----------------------------------------------------------------------------
// led_req_if: request channel of the dispatcher
// Valid/ready handshake carrying an arrival or a serve request.
// ----------------------------------------------------------------------------
interface led_req_if;
	logic                          valid;
	logic                          ready;
	logic                          req_type;
	logic [led_pkg::LANE_W-1:0]    serve_lane;
	logic [led_pkg::ID_W-1:0]      job_id;
	logic [led_pkg::ITEMS_W-1:0]   job_items;
	logic [led_pkg::SVC_W-1:0]     job_service;

	modport source (output valid, output req_type, output serve_lane, output job_id,
		output job_items, output job_service, input ready);
	modport sink (input valid, input req_type, input serve_lane, input job_id,
		input job_items, input job_service, output ready);
endinterface

// File: design/led_res_if.sv
// ----------------------------------------------------------------------------
// led_res_if: result channel of the dispatcher
// Valid/ready handshake carrying one result per request.
// ----------------------------------------------------------------------------
interface led_res_if;
	logic                          valid;
	logic                          ready;
	logic [led_pkg::LANE_W-1:0]    chosen_lane;
	logic [led_pkg::WAIT_W-1:0]    est_wait;
	logic                          lane_full;
	logic                          lane_empty;
	logic [led_pkg::ID_W-1:0]      out_job_id;
	logic [led_pkg::ITEMS_W-1:0]   out_items;
	logic [led_pkg::SVC_W-1:0]     out_service;

	modport source (output valid, output chosen_lane, output est_wait, output lane_full,
		output lane_empty, output out_job_id, output out_items, output out_service,
		input ready);
	modport sink (input valid, input chosen_lane, input est_wait, input lane_full,
		input lane_empty, input out_job_id, input out_items, input out_service,
		output ready);
endinterface

// File: design/led_ram.sv
// ----------------------------------------------------------------------------
// led_ram: generic single-write, single-read RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module led_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	// Write and registered read
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

// File: design/led_front.sv
// ----------------------------------------------------------------------------
// led_front: request intake of the dispatcher
// Accepts requests, classifies them and holds them in a two-entry queue
// that decouples the intake from the lane back end.
// ----------------------------------------------------------------------------
module led_front #(
	parameter int LANES = 4
) (
	input  logic          clk,
	input  logic          arst_n,
	led_req_if.sink       job_req,
	output logic          q_valid,
	input  logic          q_ready,
	output led_pkg::req_t q_data
);

	led_pkg::req_t entry_q [2];
	logic [1:0]    count_q;
	logic          wr_ptr_q;
	logic          rd_ptr_q;
	led_pkg::req_t cls;
	logic          push;
	logic          pop;

	assign job_req.ready = (count_q != 2'd2);
	assign push          = job_req.valid && job_req.ready;
	assign q_valid       = (count_q != 2'd0);
	assign pop           = q_valid && q_ready;
	assign q_data        = entry_q[rd_ptr_q];

	// Classify the incoming request
	always_comb begin
		cls.lane        = job_req.serve_lane;
		cls.job_id      = job_req.job_id;
		cls.job_items   = job_req.job_items;
		cls.job_service = job_req.job_service;
		if (job_req.req_type == led_pkg::REQ_ARRIVE) begin
			cls.kind = led_pkg::KIND_ARRIVE;
		end else if (3'(job_req.serve_lane) >= 3'(LANES)) begin
			cls.kind = led_pkg::KIND_SERVE_NONE;
		end else begin
			cls.kind = led_pkg::KIND_SERVE;
		end
	end

	// Store classified requests
	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= cls;
		end
	end

	// Advance queue pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q  <= 2'd0;
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
		end else begin
			if (push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			if (push && !pop) begin
				count_q <= count_q + 2'd1;
			end else if (pop && !push) begin
				count_q <= count_q - 2'd1;
			end
		end
	end

endmodule

// File: design/led_back.sv
// ----------------------------------------------------------------------------
// led_back: lane back end of the dispatcher
// Picks the lane with the least expected delay for arrivals, appends jobs
// to the lane queues in the job store, pops front jobs on serves and holds
// the result register.
// ----------------------------------------------------------------------------
module led_back #(
	parameter int LANES       = 4,
	parameter int QUEUE_DEPTH = 16
) (
	input  logic                                     clk,
	input  logic                                     arst_n,
	input  led_pkg::cfg_t                            cfg,
	input  logic                                     q_valid,
	output logic                                     q_ready,
	input  led_pkg::req_t                            q_data,
	output logic                                     ram_we,
	output logic [$clog2(LANES*QUEUE_DEPTH)-1:0]     ram_waddr,
	output logic [led_pkg::WORD_W-1:0]               ram_wdata,
	output logic                                     ram_re,
	output logic [$clog2(LANES*QUEUE_DEPTH)-1:0]     ram_raddr,
	input  logic [led_pkg::WORD_W-1:0]               ram_rdata,
	output logic                                     res_valid,
	input  logic                                     res_ready,
	output led_pkg::res_t                            res_data
);

	localparam int ADDR_W = $clog2(LANES * QUEUE_DEPTH);
	localparam int HEAD_W = $clog2(QUEUE_DEPTH);
	localparam int CNT_W  = $clog2(QUEUE_DEPTH + 1);
	localparam int PEND_W = $clog2(QUEUE_DEPTH * 255 + 1);
	localparam int SUM_W  = PEND_W + 1;
	localparam int EST_W  = SUM_W + led_pkg::RATE_W;
	localparam int LIDX_W = (LANES > 1) ? $clog2(LANES) : 1;

	typedef enum logic {
		ST_RUN,
		ST_READ
	} state_t;

	state_t                      state_q;
	logic [HEAD_W-1:0]           head_q [LANES];
	logic [CNT_W-1:0]            cnt_q  [LANES];
	logic [PEND_W-1:0]           pend_q [LANES];
	logic [led_pkg::LANE_W-1:0]  rd_lane_q;
	logic                        res_valid_q;
	led_pkg::res_t               res_q;

	logic [EST_W-1:0]            est [LANES];
	logic [EST_W-1:0]            best_est;
	logic [led_pkg::LANE_W-1:0]  best;
	logic [led_pkg::NLANES_W-1:0] n_lanes;
	logic [LIDX_W-1:0]           best_idx;
	logic [LIDX_W-1:0]           srv_idx;
	logic [LIDX_W-1:0]           rd_idx;
	logic                        best_full;
	logic [CNT_W:0]              slot_sum;
	logic [HEAD_W-1:0]           slot;
	logic [HEAD_W-1:0]           head_next;
	logic [led_pkg::WAIT_W-1:0]  est_sat;
	logic                        out_free;
	logic                        take;
	logic                        is_arrive;
	logic                        serve_hit;
	logic                        res_load;
	logic [led_pkg::ITEMS_W-1:0] rd_items;

	assign out_free  = !res_valid_q || res_ready;
	assign q_ready   = (state_q == ST_RUN) && out_free;
	assign take      = q_valid && q_ready;
	assign is_arrive = (q_data.kind == led_pkg::KIND_ARRIVE);
	assign srv_idx   = q_data.lane[LIDX_W-1:0];
	assign rd_idx    = rd_lane_q[LIDX_W-1:0];
	assign serve_hit = (q_data.kind == led_pkg::KIND_SERVE) && (cnt_q[srv_idx] != '0);
	assign rd_items  = ram_rdata[led_pkg::SVC_W +: led_pkg::ITEMS_W];
	assign res_load  = (state_q == ST_READ) || (take && (is_arrive || !serve_hit));

	// Estimate the wait of every lane
	always_comb begin
		for (int i = 0; i < LANES; i++) begin
			est[i] = EST_W'({1'b0, pend_q[i]} + SUM_W'(q_data.job_items))
				* EST_W'(cfg.rate[i]);
		end
	end

	// Clamp lanes in use and pick the lowest estimate, lower lane on a tie
	always_comb begin
		if (cfg.lanes_in_use == '0) begin
			n_lanes = 3'd1;
		end else if (cfg.lanes_in_use > 3'(LANES)) begin
			n_lanes = 3'(LANES);
		end else begin
			n_lanes = cfg.lanes_in_use;
		end
		best     = '0;
		best_est = est[0];
		for (int i = 1; i < LANES; i++) begin
			if ((3'(i) < n_lanes) && (est[i] < best_est)) begin
				best     = 2'(i);
				best_est = est[i];
			end
		end
		best_idx  = best[LIDX_W-1:0];
		best_full = (cnt_q[best_idx] == CNT_W'(QUEUE_DEPTH));
		est_sat   = (32'(best_est) > 32'hFFFF) ? 16'hFFFF : 16'(best_est);
	end

	// Tail slot of the winning lane and next head of the served lane
	always_comb begin
		slot_sum = (CNT_W+1)'(head_q[best_idx]) + (CNT_W+1)'(cnt_q[best_idx]);
		if (slot_sum >= (CNT_W+1)'(QUEUE_DEPTH)) begin
			slot_sum = slot_sum - (CNT_W+1)'(QUEUE_DEPTH);
		end
		slot = slot_sum[HEAD_W-1:0];
		if (head_q[srv_idx] == HEAD_W'(QUEUE_DEPTH - 1)) begin
			head_next = '0;
		end else begin
			head_next = head_q[srv_idx] + HEAD_W'(1);
		end
	end

	// Job store access
	assign ram_we    = take && is_arrive && !best_full;
	assign ram_waddr = ADDR_W'(best) * ADDR_W'(QUEUE_DEPTH) + ADDR_W'(slot);
	assign ram_wdata = {q_data.job_id, q_data.job_items, q_data.job_service};
	assign ram_re    = take && serve_hit;
	assign ram_raddr = ADDR_W'(q_data.lane) * ADDR_W'(QUEUE_DEPTH)
		+ ADDR_W'(head_q[srv_idx]);

	assign res_valid = res_valid_q;
	assign res_data  = res_q;

	// Hold lane state, sequence serves and register results
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_RUN;
			res_valid_q <= 1'b0;
			res_q       <= '0;
			rd_lane_q   <= '0;
			for (int i = 0; i < LANES; i++) begin
				head_q[i] <= '0;
				cnt_q[i]  <= '0;
				pend_q[i] <= '0;
			end
		end else begin
			// Raise valid on a new result, drop it once the result is taken
			if (res_load) begin
				res_valid_q <= 1'b1;
			end else if (res_ready) begin
				res_valid_q <= 1'b0;
			end
			case (state_q)
				ST_RUN: begin
					if (take) begin
						if (is_arrive) begin
							res_q <= '{chosen_lane: best, est_wait: est_sat,
								lane_full: best_full, default: '0};
							if (!best_full) begin
								cnt_q[best_idx]  <= cnt_q[best_idx] + CNT_W'(1);
								pend_q[best_idx] <= pend_q[best_idx]
									+ PEND_W'(q_data.job_items);
							end
						end else if (serve_hit) begin
							head_q[srv_idx] <= head_next;
							cnt_q[srv_idx]  <= cnt_q[srv_idx] - CNT_W'(1);
							rd_lane_q       <= q_data.lane;
							state_q         <= ST_READ;
						end else begin
							res_q <= '{chosen_lane: q_data.lane, lane_empty: 1'b1,
								default: '0};
						end
					end
				end
				ST_READ: begin
					// Read data is back: drop the popped items and report the job
					res_q <= '{chosen_lane: rd_lane_q,
						out_job_id: ram_rdata[led_pkg::WORD_W-1 -: led_pkg::ID_W],
						out_items: rd_items,
						out_service: ram_rdata[led_pkg::SVC_W-1:0],
						default: '0};
					if (pend_q[rd_idx] >= PEND_W'(rd_items)) begin
						pend_q[rd_idx] <= pend_q[rd_idx] - PEND_W'(rd_items);
					end else begin
						pend_q[rd_idx] <= '0;
					end
					state_q <= ST_RUN;
				end
				default: begin
					state_q <= ST_RUN;
				end
			endcase
		end
	end

endmodule

// File: design/least_expected_delay_dispatcher.sv
// Results: an arrival result is registered once the back end takes the queued
// request; a serve result waits for the registered job store read in ST_READ.
// Throughput: one arrival per cycle while results are taken; a serve of a non-empty
// lane holds the back end in ST_READ while its job store read returns.
// Reset clears lane counts, head pointers and item sums, sets lanes_in_use to 4
// and all rates to 2; the job store is not cleared and takes no sweep.
// ----------------------------------------------------------------------------
// least_expected_delay_dispatcher: least-expected-delay job dispatcher
// Front end classifies and queues requests, back end dispatches arrivals
// to the lane with the smallest estimated wait and serves lane front jobs.
// ----------------------------------------------------------------------------
module least_expected_delay_dispatcher #(
	parameter int LANES       = 4,
	parameter int QUEUE_DEPTH = 16
) (
	input  logic                              clk,
	input  logic                              arst_n,
	led_req_if.sink                           job_req,
	led_res_if.source                         job_res,
	input  logic                              cfg_we,
	input  logic [led_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [led_pkg::CFG_DAT_W-1:0]     cfg_data
);

	localparam int DEPTH  = LANES * QUEUE_DEPTH;
	localparam int ADDR_W = $clog2(DEPTH);

	led_pkg::cfg_t                cfg_q;
	logic                         q_valid;
	logic                         q_ready;
	led_pkg::req_t                q_data;
	logic                         ram_we;
	logic [ADDR_W-1:0]            ram_waddr;
	logic [led_pkg::WORD_W-1:0]   ram_wdata;
	logic                         ram_re;
	logic [ADDR_W-1:0]            ram_raddr;
	logic [led_pkg::WORD_W-1:0]   ram_rdata;
	led_pkg::res_t                res_data;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.lanes_in_use <= led_pkg::LANES_RST;
			for (int i = 0; i < led_pkg::RATE_REGS; i++) begin
				cfg_q.rate[i] <= led_pkg::RATE_RST;
			end
		end else if (cfg_we) begin
			case (cfg_index)
				led_pkg::REG_LANES: cfg_q.lanes_in_use <= cfg_data[led_pkg::NLANES_W-1:0];
				led_pkg::REG_RATE0: cfg_q.rate[0] <= cfg_data;
				led_pkg::REG_RATE1: cfg_q.rate[1] <= cfg_data;
				led_pkg::REG_RATE2: cfg_q.rate[2] <= cfg_data;
				led_pkg::REG_RATE3: cfg_q.rate[3] <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	led_front #(
		.LANES(LANES)
	) u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.job_req (job_req),
		.q_valid (q_valid),
		.q_ready (q_ready),
		.q_data  (q_data)
	);

	led_ram #(
		.WIDTH(led_pkg::WORD_W),
		.DEPTH(DEPTH)
	) u_job_store (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	led_back #(
		.LANES       (LANES),
		.QUEUE_DEPTH (QUEUE_DEPTH)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.q_valid   (q_valid),
		.q_ready   (q_ready),
		.q_data    (q_data),
		.ram_we    (ram_we),
		.ram_waddr (ram_waddr),
		.ram_wdata (ram_wdata),
		.ram_re    (ram_re),
		.ram_raddr (ram_raddr),
		.ram_rdata (ram_rdata),
		.res_valid (job_res.valid),
		.res_ready (job_res.ready),
		.res_data  (res_data)
	);

	// Drive the result channel payload
	assign job_res.chosen_lane = res_data.chosen_lane;
	assign job_res.est_wait    = res_data.est_wait;
	assign job_res.lane_full   = res_data.lane_full;
	assign job_res.lane_empty  = res_data.lane_empty;
	assign job_res.out_job_id  = res_data.out_job_id;
	assign job_res.out_items   = res_data.out_items;
	assign job_res.out_service = res_data.out_service;

endmodule

// File: bench/least_expected_delay_dispatcher_test.sv
// ----------------------------------------------------------------------------
// least_expected_delay_dispatcher_test: testbench of the expected-delay dispatcher
// Sends arrival and serve requests with random gaps and result stalls. A lane
// model predicts the result of each request. Every field is checked in order.
// ----------------------------------------------------------------------------
module least_expected_delay_dispatcher_test;

	localparam int NUM_LANES    = 4;
	localparam int LANE_DEPTH   = 16;
	localparam int PERIOD_HALF  = 10;
	localparam int RESET_CYCLES = 6;
	localparam int DRAIN_CYCLES = 8;
	localparam int CYCLE_LIMIT  = 400000;
	localparam int PHASES       = 12;
	localparam int PHASE_ITEMS  = 152;
	localparam int MAX_GAP      = 8;
	localparam int HOLD_CYCLES  = 300;
	localparam int MAX_WAIT     = 65535;

	typedef struct packed {
		logic                         req_type;
		logic [led_pkg::LANE_W-1:0]   serve_lane;
		logic [led_pkg::ID_W-1:0]     job_id;
		logic [led_pkg::ITEMS_W-1:0]  job_items;
		logic [led_pkg::SVC_W-1:0]    job_service;
	} request_t;

	// Lane model: job slots, queue pointers and item sums per lane
	class lane_dispatch_model;
		logic [led_pkg::WORD_W-1:0] job_slots [NUM_LANES][LANE_DEPTH];
		int unsigned front [NUM_LANES];
		int unsigned queued [NUM_LANES];
		int unsigned item_sum [NUM_LANES];
		int unsigned lane_rate [NUM_LANES];
		int unsigned active_lanes;
		led_pkg::res_t awaited_results [$];
		int errors;
		int requests;
		int dropped;
		int empty_serves;
		int served_jobs;

		function new();
			for (int i = 0; i < NUM_LANES; i++) begin
				front[i] = 0;
				queued[i] = 0;
				item_sum[i] = 0;
				lane_rate[i] = 32'(led_pkg::RATE_RST);
			end
			active_lanes = 32'(led_pkg::LANES_RST);
			errors = 0;
			requests = 0;
			dropped = 0;
			empty_serves = 0;
			served_jobs = 0;
		endfunction

		function void write_register(logic [led_pkg::CFG_IDX_W-1:0] index,
			logic [led_pkg::CFG_DAT_W-1:0] data);
			case (index)
				led_pkg::REG_LANES: active_lanes = 32'(data[led_pkg::NLANES_W-1:0]);
				led_pkg::REG_RATE0: lane_rate[0] = 32'(data);
				led_pkg::REG_RATE1: lane_rate[1] = 32'(data);
				led_pkg::REG_RATE2: lane_rate[2] = 32'(data);
				led_pkg::REG_RATE3: lane_rate[3] = 32'(data);
				default: ;
			endcase
		endfunction

		// Dispatch or serve one request and queue the result it must produce
		function void note_request(request_t r);
			led_pkg::res_t res;
			int unsigned span;
			int unsigned best;
			int unsigned slot;
			int unsigned lane;
			longint unsigned est;
			longint unsigned best_est;
			logic [led_pkg::WORD_W-1:0] word;
			res = '0;
			requests++;
			if (r.req_type == led_pkg::REQ_ARRIVE) begin
				span = active_lanes;
				if (span < 1)
					span = 1;
				if (span > NUM_LANES)
					span = NUM_LANES;
				best = 0;
				best_est = 0;
				// Lowest estimate wins, the lower lane on a tie
				for (int i = 0; i < span; i++) begin
					est = 64'((item_sum[i] + 32'(r.job_items)) * lane_rate[i]);
					if (i == 0 || est < best_est) begin
						best_est = est;
						best = unsigned'(i);
					end
				end
				res.chosen_lane = best[led_pkg::LANE_W-1:0];
				if (best_est > MAX_WAIT)
					res.est_wait = '1;
				else
					res.est_wait = best_est[led_pkg::WAIT_W-1:0];
				if (queued[best] >= LANE_DEPTH) begin
					res.lane_full = 1'b1;
					dropped++;
				end else begin
					slot = (front[best] + queued[best]) % LANE_DEPTH;
					job_slots[best][slot] = {r.job_id, r.job_items, r.job_service};
					queued[best]++;
					item_sum[best] += 32'(r.job_items);
				end
			end else begin
				lane = 32'(r.serve_lane);
				res.chosen_lane = r.serve_lane;
				if (lane >= NUM_LANES || queued[lane] == 0) begin
					res.lane_empty = 1'b1;
					empty_serves++;
				end else begin
					word = job_slots[lane][front[lane]];
					res.out_job_id = word[led_pkg::WORD_W-1 -: led_pkg::ID_W];
					res.out_items = word[led_pkg::SVC_W +: led_pkg::ITEMS_W];
					res.out_service = word[led_pkg::SVC_W-1:0];
					front[lane] = (front[lane] + 1) % LANE_DEPTH;
					queued[lane]--;
					item_sum[lane] = (item_sum[lane] >= 32'(res.out_items)) ?
						item_sum[lane] - 32'(res.out_items) : 0;
					served_jobs++;
				end
			end
			awaited_results.push_back(res);
		endfunction

		function void check_field(string field, logic [31:0] want, logic [31:0] got);
			if (got !== want) begin
				$display("%0t: mismatch on %s: expected 0x%0h, actual 0x%0h",
					$time, field, want, got);
				errors++;
			end
		endfunction

		// Compare one result with the oldest awaited one
		function void check_result(led_pkg::res_t got);
			led_pkg::res_t want;
			if (awaited_results.size() == 0) begin
				$display("%0t: result with no request pending: lane %0d wait %0d id 0x%0h",
					$time, got.chosen_lane, got.est_wait, got.out_job_id);
				errors++;
				return;
			end
			want = awaited_results.pop_front();
			check_field("chosen_lane", 32'(want.chosen_lane), 32'(got.chosen_lane));
			check_field("est_wait", 32'(want.est_wait), 32'(got.est_wait));
			check_field("lane_full", 32'(want.lane_full), 32'(got.lane_full));
			check_field("lane_empty", 32'(want.lane_empty), 32'(got.lane_empty));
			check_field("out_job_id", 32'(want.out_job_id), 32'(got.out_job_id));
			check_field("out_items", 32'(want.out_items), 32'(got.out_items));
			check_field("out_service", 32'(want.out_service), 32'(got.out_service));
		endfunction
	endclass

	logic clk;
	logic arst_n;
	logic cfg_we;
	logic [led_pkg::CFG_IDX_W-1:0] cfg_index;
	logic [led_pkg::CFG_DAT_W-1:0] cfg_data;

	lane_dispatch_model dispatch_model;
	int unsigned sender_gap_max;
	int unsigned res_stall_max;
	int unsigned hold_off_cycles;
	int unsigned config_count;
	int unsigned cycle_count = 0;

	led_req_if job_req_ch ();
	led_res_if job_res_ch ();

	least_expected_delay_dispatcher #(
		.LANES       (NUM_LANES),
		.QUEUE_DEPTH (LANE_DEPTH)
	) u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.job_req   (job_req_ch),
		.job_res   (job_res_ch),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always #PERIOD_HALF clk = ~clk;

	// End the run if it hangs
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("%0t: timeout after %0d cycles, %0d results outstanding", $time,
				cycle_count, dispatch_model.awaited_results.size());
			$display("least_expected_delay_dispatcher_test: FAIL");
			$finish;
		end
	end

	// Check results first, then record the request accepted at the same edge
	always @(posedge clk) begin
		led_pkg::res_t seen_result;
		request_t seen_request;
		if (arst_n) begin
			if (job_res_ch.valid && job_res_ch.ready) begin
				seen_result.chosen_lane = job_res_ch.chosen_lane;
				seen_result.est_wait = job_res_ch.est_wait;
				seen_result.lane_full = job_res_ch.lane_full;
				seen_result.lane_empty = job_res_ch.lane_empty;
				seen_result.out_job_id = job_res_ch.out_job_id;
				seen_result.out_items = job_res_ch.out_items;
				seen_result.out_service = job_res_ch.out_service;
				dispatch_model.check_result(seen_result);
			end
			if (job_req_ch.valid && job_req_ch.ready) begin
				seen_request.req_type = job_req_ch.req_type;
				seen_request.serve_lane = job_req_ch.serve_lane;
				seen_request.job_id = job_req_ch.job_id;
				seen_request.job_items = job_req_ch.job_items;
				seen_request.job_service = job_req_ch.job_service;
				dispatch_model.note_request(seen_request);
			end
		end
	end

	// Result side: random stalls, plus one long hold-off on demand
	initial begin
		int unsigned stall;
		bit held;
		held = 1'b0;
		job_res_ch.ready = 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			@(negedge clk);
			if (hold_off_cycles > 0 && !held) begin
				job_res_ch.ready <= 1'b0;
				repeat (hold_off_cycles) @(negedge clk);
				held = 1'b1;
			end
			stall = $urandom_range(0, res_stall_max);
			if (stall > 0) begin
				job_res_ch.ready <= 1'b0;
				repeat (stall) @(negedge clk);
			end
			job_res_ch.ready <= 1'b1;
			do
				@(posedge clk);
			while (!(job_res_ch.valid && job_res_ch.ready));
		end
	end

	function automatic request_t arrival(logic [led_pkg::ID_W-1:0] id,
		logic [led_pkg::ITEMS_W-1:0] items, logic [led_pkg::SVC_W-1:0] svc);
		request_t r;
		r.req_type = led_pkg::REQ_ARRIVE;
		r.serve_lane = (led_pkg::LANE_W)'($urandom);
		r.job_id = id;
		r.job_items = items;
		r.job_service = svc;
		return r;
	endfunction

	function automatic request_t serve_of(logic [led_pkg::LANE_W-1:0] lane);
		request_t r;
		r.req_type = led_pkg::REQ_SERVE;
		r.serve_lane = lane;
		r.job_id = (led_pkg::ID_W)'($urandom);
		r.job_items = (led_pkg::ITEMS_W)'($urandom);
		r.job_service = (led_pkg::SVC_W)'($urandom);
		return r;
	endfunction

	function automatic request_t random_request(int unsigned arrive_pct);
		request_t r;
		r.req_type = ($urandom_range(1, 100) <= arrive_pct) ?
			led_pkg::REQ_ARRIVE : led_pkg::REQ_SERVE;
		r.serve_lane = (led_pkg::LANE_W)'($urandom);
		r.job_id = (led_pkg::ID_W)'($urandom);
		case ($urandom_range(0, 7))
			0: r.job_items = '0;
			1: r.job_items = '1;
			default: r.job_items = (led_pkg::ITEMS_W)'($urandom);
		endcase
		r.job_service = (led_pkg::SVC_W)'($urandom);
		return r;
	endfunction

	// Offer one request after a random gap; return at the next falling edge
	task automatic send_request(request_t r);
		int unsigned gap;
		gap = $urandom_range(0, sender_gap_max);
		if (gap > 0) begin
			job_req_ch.valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		job_req_ch.valid <= 1'b1;
		job_req_ch.req_type <= r.req_type;
		job_req_ch.serve_lane <= r.serve_lane;
		job_req_ch.job_id <= r.job_id;
		job_req_ch.job_items <= r.job_items;
		job_req_ch.job_service <= r.job_service;
		do
			@(posedge clk);
		while (!job_req_ch.ready);
		@(negedge clk);
	endtask

	// Stop offering and wait for every awaited result, then let the block settle
	task automatic wait_drained();
		job_req_ch.valid <= 1'b0;
		while (dispatch_model.awaited_results.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		@(negedge clk);
	endtask

	task automatic program_register(logic [led_pkg::CFG_IDX_W-1:0] index,
		logic [led_pkg::CFG_DAT_W-1:0] data);
		cfg_we <= 1'b1;
		cfg_index <= index;
		cfg_data <= data;
		dispatch_model.write_register(index, data);
		@(negedge clk);
	endtask

	// Write all registers, and one unused index, while the block is idle
	task automatic apply_config(logic [led_pkg::CFG_DAT_W-1:0] lanes_code,
		logic [led_pkg::RATE_REGS-1:0][led_pkg::RATE_W-1:0] rates);
		wait_drained();
		program_register(led_pkg::REG_LANES, lanes_code);
		program_register(led_pkg::REG_RATE0, rates[0]);
		program_register(led_pkg::REG_RATE1, rates[1]);
		program_register(led_pkg::REG_RATE2, rates[2]);
		program_register(led_pkg::REG_RATE3, rates[3]);
		program_register(led_pkg::REG_RATE3
			+ (led_pkg::CFG_IDX_W)'($urandom_range(1, 3)),
			(led_pkg::CFG_DAT_W)'($urandom));
		cfg_we <= 1'b0;
		@(negedge clk);
		config_count++;
	endtask

	initial begin
		logic [led_pkg::CFG_DAT_W-1:0] lanes_code;
		logic [led_pkg::RATE_REGS-1:0][led_pkg::RATE_W-1:0] rates;
		int unsigned arrive_pct;
		dispatch_model = new();
		clk = 1'b0;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		job_req_ch.valid = 1'b0;
		job_req_ch.req_type = led_pkg::REQ_ARRIVE;
		job_req_ch.serve_lane = '0;
		job_req_ch.job_id = '0;
		job_req_ch.job_items = '0;
		job_req_ch.job_service = '0;
		sender_gap_max = MAX_GAP;
		res_stall_max = MAX_GAP;
		hold_off_cycles = 0;
		config_count = 0;
		repeat (RESET_CYCLES) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Reset configuration: empty serve, field extremes, lane ties
		send_request(serve_of(2'd0));
		send_request(arrival(16'hFFFF, 8'hFF, 8'hFF));
		send_request(arrival(16'h0000, 8'h00, 8'h00));
		send_request(arrival(16'h1234, 8'h01, 8'h5A));
		send_request(serve_of(2'd0));

		// Zero lanes in use acts as one lane; a zero rate estimates no wait
		apply_config(4'd0, {4'd15, 4'd15, 4'd15, 4'd0});
		send_request(arrival(16'hA5A5, 8'd200, 8'h33));

		// Lane count above the maximum is clamped; zero-rate lanes tie
		apply_config(4'd7, {4'd15, 4'd0, 4'd0, 4'd15});
		send_request(arrival(16'h5A5A, 8'hFF, 8'hC3));

		// Fill lane zero until an arrival is dropped, then serve a lane out of use
		apply_config(4'd1, {4'd2, 4'd2, 4'd2, 4'd15});
		for (int i = 0; i < LANE_DEPTH; i++)
			send_request(arrival((led_pkg::ID_W)'(16'h8000 + i), 8'hFF,
				(led_pkg::SVC_W)'(i)));
		send_request(serve_of(2'd1));

		// Random phases, each under its own configuration
		for (int phase = 0; phase < PHASES; phase++) begin
			lanes_code = (led_pkg::CFG_DAT_W)'($urandom);
			rates = (led_pkg::RATE_REGS * led_pkg::RATE_W)'($urandom);
			arrive_pct = $urandom_range(30, 85);
			sender_gap_max = MAX_GAP;
			res_stall_max = MAX_GAP;
			case (phase)
				0: begin
					lanes_code = 4'd4;
					rates = '1;
				end
				1: begin
					lanes_code = 4'd1;
					rates = '0;
				end
				2: lanes_code = 4'd0;
				3: begin
					lanes_code = 4'd7;
					rates = '0;
				end
				default: ;
			endcase
			apply_config(lanes_code, rates);
			// Hold results back while requests keep coming to fill the block
			if (phase == 4) begin
				sender_gap_max = 0;
				arrive_pct = 70;
				hold_off_cycles = HOLD_CYCLES;
			end
			// Run a stretch with no idling on either side
			if (phase == 5) begin
				sender_gap_max = 0;
				res_stall_max = 0;
			end
			for (int n = 0; n < PHASE_ITEMS; n++) begin
				// Pause until everything has come back
				if (phase == 6 && n == PHASE_ITEMS / 2)
					wait_drained();
				send_request(random_request(arrive_pct));
			end
		end

		wait_drained();
		$display("Checked %0d requests over %0d configurations:", dispatch_model.requests,
			config_count);
		$display("%0d jobs served, %0d arrivals dropped on full lanes, %0d empty serves",
			dispatch_model.served_jobs, dispatch_model.dropped, dispatch_model.empty_serves);
		if (dispatch_model.errors == 0)
			$display("least_expected_delay_dispatcher_test: PASS");
		else
			$display("least_expected_delay_dispatcher_test: FAIL");
		$finish;
	end

endmodule

// File: sim.f
design/led_pkg.sv
design/led_req_if.sv
design/led_res_if.sv
design/led_ram.sv
design/led_front.sv
design/led_back.sv
design/least_expected_delay_dispatcher.sv
bench/least_expected_delay_dispatcher_test.sv
